FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/bts_pkg.sv
package bts_pkg;

  localparam int DataW = 8;
  localparam int SetW  = 4;
  localparam int CodeW = 15;

  // control bytes
  localparam logic [7:0] BYTE_LS0   = 8'h0F;
  localparam logic [7:0] BYTE_LS1   = 8'h0E;
  localparam logic [7:0] BYTE_SS2   = 8'h19;
  localparam logic [7:0] BYTE_SS3   = 8'h1D;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_SP    = 8'h20;
  localparam logic [7:0] BYTE_SP_GR = 8'hA0;
  localparam logic [7:0] GL_LO      = 8'h21;
  localparam logic [7:0] GL_HI      = 8'h7E;
  localparam logic [7:0] GR_LO      = 8'hA1;
  localparam logic [7:0] GR_HI      = 8'hFE;

  // escape sequence intermediates and finals
  localparam logic [7:0] ESC_LS2    = 8'h6E;
  localparam logic [7:0] ESC_LS3    = 8'h6F;
  localparam logic [7:0] ESC_LS1R   = 8'h7E;
  localparam logic [7:0] ESC_LS2R   = 8'h7D;
  localparam logic [7:0] ESC_LS3R   = 8'h7C;
  localparam logic [7:0] ESC_DBL    = 8'h24;
  localparam logic [7:0] ESC_G0     = 8'h28;
  localparam logic [7:0] ESC_G1     = 8'h29;
  localparam logic [7:0] ESC_G2     = 8'h2A;
  localparam logic [7:0] ESC_G3     = 8'h2B;
  localparam logic [7:0] ESC_DRCS   = 8'h20;
  localparam logic [7:0] ESC_MACRO  = 8'h70;

  // escape parser position
  localparam logic [2:0] ESCP_IDLE   = 3'd0;
  localparam logic [2:0] ESCP_FIRST  = 3'd1;
  localparam logic [2:0] ESCP_SECOND = 3'd2;
  localparam logic [2:0] ESCP_THIRD  = 3'd3;
  localparam logic [2:0] ESCP_FOURTH = 3'd4;

  // code sets
  localparam logic [SetW-1:0] SET_DRCS     = 4'd0;
  localparam logic [SetW-1:0] SET_KANJI    = 4'd1;
  localparam logic [SetW-1:0] SET_ALNUM    = 4'd2;
  localparam logic [SetW-1:0] SET_HIRA     = 4'd3;
  localparam logic [SetW-1:0] SET_KATA     = 4'd4;
  localparam logic [SetW-1:0] SET_MOSAIC_A = 4'd5;
  localparam logic [SetW-1:0] SET_MOSAIC_B = 4'd6;
  localparam logic [SetW-1:0] SET_MOSAIC_C = 4'd7;
  localparam logic [SetW-1:0] SET_MOSAIC_D = 4'd8;
  localparam logic [SetW-1:0] SET_P_ALNUM  = 4'd9;
  localparam logic [SetW-1:0] SET_P_HIRA   = 4'd10;
  localparam logic [SetW-1:0] SET_P_KATA   = 4'd11;
  localparam logic [SetW-1:0] SET_JIS_KATA = 4'd12;
  localparam logic [SetW-1:0] SET_JIS_K1   = 4'd13;
  localparam logic [SetW-1:0] SET_JIS_K2   = 4'd14;
  localparam logic [SetW-1:0] SET_ADD_SYM  = 4'd15;

  typedef struct packed {
    logic            is_space;
    logic [SetW-1:0] char_set;
    logic [CodeW-1:0] char_code;
    logic            double_byte;
  } bts_result_t;

  function automatic logic set_is_wide(input logic [SetW-1:0] s);
    return s == SET_KANJI || s == SET_JIS_K1 || s == SET_JIS_K2 || s == SET_ADD_SYM;
  endfunction

  function automatic logic set_emits(input logic [SetW-1:0] s);
    return (s >= SET_KANJI && s <= SET_KATA) || (s >= SET_P_ALNUM && s <= SET_JIS_K2);
  endfunction

  // {hit, set} for a graphic set final byte
  function automatic logic [SetW:0] graphic_final(input logic [7:0] b);
    logic [SetW:0] r;
    case (b)
      8'h42:   r = {1'b1, SET_KANJI};
      8'h4A:   r = {1'b1, SET_ALNUM};
      8'h30:   r = {1'b1, SET_HIRA};
      8'h31:   r = {1'b1, SET_KATA};
      8'h32:   r = {1'b1, SET_MOSAIC_A};
      8'h33:   r = {1'b1, SET_MOSAIC_B};
      8'h34:   r = {1'b1, SET_MOSAIC_C};
      8'h35:   r = {1'b1, SET_MOSAIC_D};
      8'h36:   r = {1'b1, SET_P_ALNUM};
      8'h37:   r = {1'b1, SET_P_HIRA};
      8'h38:   r = {1'b1, SET_P_KATA};
      8'h49:   r = {1'b1, SET_JIS_KATA};
      8'h39:   r = {1'b1, SET_JIS_K1};
      8'h3A:   r = {1'b1, SET_JIS_K2};
      8'h3B:   r = {1'b1, SET_ADD_SYM};
      default: r = {1'b0, SET_DRCS};
    endcase
    return r;
  endfunction

  function automatic logic drcs_final(input logic [7:0] b);
    return (b[7:4] == 4'h4) || (b == ESC_MACRO);
  endfunction

endpackage

FILE: rtl/broadcast_text_shift_decoder_top.sv
// broadcast text decoder, 8-unit code with iso 2022 style code extension
//
// input: one byte of the string per transfer on s_tdata, s_tlast on the
// final byte; after that byte every shift, designation and escape state
// goes back to its default and a half-received double-byte character is
// dropped
// output: zero or one result per input byte; m_tuser flags a space or a
// two-byte code, m_tdata carries the set number and 7- or 14-bit code
// output register: a result is on m_tdata in the cycle after its byte's transfer
// throughput: one byte per cycle unless a result stalls; the shift state and
// the result register are updated on each byte, so bytes stream back to back
// stall: while a result waits with m_tready low, s_tready drops; a byte is
// taken again in the cycle the waiting result transfers
// reset: rst is synchronous; it clears the output valid flag and loads the
// default designations (kanji, alphanumeric, hiragana, katakana)
module broadcast_text_shift_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] char_set, [18:4] char_code, zero above
  output logic [1:0]  m_tuser    // [0] is_space, [1] double_byte
);
  import bts_pkg::*;

  logic        accept;
  logic        res_valid;
  bts_result_t res;
  bts_result_t out_res;

  assign accept = s_tvalid && s_tready;

  bts_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  bts_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .res_valid  (res_valid),
    .res        (res),
    .can_accept (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = {5'd0, out_res.char_code, out_res.char_set};
  assign m_tuser = {out_res.double_byte, out_res.is_space};

endmodule

FILE: rtl/bts_decode.sv
module bts_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 res_valid,
  output bts_pkg::bts_result_t res
);
  import bts_pkg::*;

  logic [SetW-1:0] designation [4];
  logic [1:0]      gl_select;
  logic [1:0]      gr_select;
  logic            ss_valid;
  logic [1:0]      ss_select;
  logic [2:0]      esc_count;
  logic [1:0]      esc_target;
  logic            esc_drcs;
  logic            pend_valid;
  logic [6:0]      pend_first;
  logic [SetW-1:0] pend_set;

  logic            wr_en;
  logic [SetW-1:0] wr_set;
  logic [1:0]      gl_select_next;
  logic [1:0]      gr_select_next;
  logic            ss_valid_next;
  logic [1:0]      ss_select_next;
  logic [2:0]      esc_count_next;
  logic [1:0]      esc_target_next;
  logic            esc_drcs_next;
  logic            pend_valid_next;
  logic [6:0]      pend_first_next;
  logic [SetW-1:0] pend_set_next;

  logic            in_gl;
  logic            in_gr;
  logic [1:0]      rd_idx;
  logic [SetW-1:0] cur_set;
  logic [SetW:0]   gf;

  assign in_gl   = data_byte >= GL_LO && data_byte <= GL_HI;
  assign in_gr   = data_byte >= GR_LO && data_byte <= GR_HI;
  // one lookup serves both halves of the code table
  assign rd_idx  = in_gl ? (ss_valid ? ss_select : gl_select) : gr_select;
  assign cur_set = designation[rd_idx];
  assign gf      = graphic_final(data_byte);

  always_comb begin
    wr_en           = 1'b0;
    wr_set          = SET_DRCS;
    gl_select_next  = gl_select;
    gr_select_next  = gr_select;
    ss_valid_next   = ss_valid;
    ss_select_next  = ss_select;
    esc_count_next  = esc_count;
    esc_target_next = esc_target;
    esc_drcs_next   = esc_drcs;
    pend_valid_next = pend_valid;
    pend_first_next = pend_first;
    pend_set_next   = pend_set;
    res_valid       = 1'b0;
    res             = '0;

    if (pend_valid) begin
      pend_valid_next = 1'b0;
      if (set_emits(pend_set)) begin
        res_valid       = 1'b1;
        res.char_set    = pend_set;
        // first byte sits at bits 14:8, second at bits 6:0
        res.char_code   = {pend_first, 1'b0, data_byte[6:0]};
        res.double_byte = 1'b1;
      end
    end else if (esc_count != ESCP_IDLE) begin
      case (esc_count)
        ESCP_FIRST: begin
          esc_count_next = ESCP_IDLE;
          case (data_byte)
            ESC_LS2:  gl_select_next = 2'd2;
            ESC_LS3:  gl_select_next = 2'd3;
            ESC_LS1R: gr_select_next = 2'd1;
            ESC_LS2R: gr_select_next = 2'd2;
            ESC_LS3R: gr_select_next = 2'd3;
            ESC_DBL, ESC_G0: begin
              esc_target_next = 2'd0;
              esc_count_next  = ESCP_SECOND;
            end
            ESC_G1: begin
              esc_target_next = 2'd1;
              esc_count_next  = ESCP_SECOND;
            end
            ESC_G2: begin
              esc_target_next = 2'd2;
              esc_count_next  = ESCP_SECOND;
            end
            ESC_G3: begin
              esc_target_next = 2'd3;
              esc_count_next  = ESCP_SECOND;
            end
            default: ;
          endcase
        end
        ESCP_SECOND: begin
          esc_count_next = ESCP_IDLE;
          if (gf[SetW]) begin
            wr_en  = 1'b1;
            wr_set = gf[SetW-1:0];
          end else begin
            case (data_byte)
              ESC_DRCS: begin
                esc_drcs_next  = 1'b1;
                esc_count_next = ESCP_THIRD;
              end
              ESC_G0: begin
                esc_drcs_next   = 1'b1;
                esc_target_next = 2'd0;
                esc_count_next  = ESCP_THIRD;
              end
              ESC_G1: begin
                esc_drcs_next   = 1'b0;
                esc_target_next = 2'd1;
                esc_count_next  = ESCP_THIRD;
              end
              ESC_G2: begin
                esc_drcs_next   = 1'b0;
                esc_target_next = 2'd2;
                esc_count_next  = ESCP_THIRD;
              end
              ESC_G3: begin
                esc_drcs_next   = 1'b0;
                esc_target_next = 2'd3;
                esc_count_next  = ESCP_THIRD;
              end
              default: ;
            endcase
          end
        end
        ESCP_THIRD: begin
          esc_count_next = ESCP_IDLE;
          if (!esc_drcs && gf[SetW]) begin
            wr_en  = 1'b1;
            wr_set = gf[SetW-1:0];
          end else if (esc_drcs && drcs_final(data_byte)) begin
            wr_en  = 1'b1;
            wr_set = SET_DRCS;
          end else if (data_byte == ESC_DRCS) begin
            esc_drcs_next  = 1'b1;
            esc_count_next = ESCP_FOURTH;
          end
        end
        ESCP_FOURTH: begin
          esc_count_next = ESCP_IDLE;
          if (drcs_final(data_byte)) begin
            wr_en  = 1'b1;
            wr_set = SET_DRCS;
          end
        end
        default: esc_count_next = ESCP_IDLE;
      endcase
    end else if (in_gl || in_gr) begin
      if (in_gl) begin
        ss_valid_next = 1'b0;
      end
      if (set_is_wide(cur_set)) begin
        pend_valid_next = 1'b1;
        pend_first_next = data_byte[6:0];
        pend_set_next   = cur_set;
      end else if (set_emits(cur_set)) begin
        res_valid     = 1'b1;
        res.char_set  = cur_set;
        res.char_code = {8'd0, data_byte[6:0]};
      end
    end else begin
      case (data_byte)
        BYTE_LS0: gl_select_next = 2'd0;
        BYTE_LS1: gl_select_next = 2'd1;
        BYTE_SS2: begin
          ss_valid_next  = 1'b1;
          ss_select_next = 2'd2;
        end
        BYTE_SS3: begin
          ss_valid_next  = 1'b1;
          ss_select_next = 2'd3;
        end
        BYTE_ESC: esc_count_next = ESCP_FIRST;
        BYTE_SP, BYTE_SP_GR: begin
          res_valid    = 1'b1;
          res.is_space = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      designation[0] <= SET_KANJI;
      designation[1] <= SET_ALNUM;
      designation[2] <= SET_HIRA;
      designation[3] <= SET_KATA;
      gl_select      <= 2'd0;
      gr_select      <= 2'd2;
      ss_valid       <= 1'b0;
      ss_select      <= 2'd0;
      esc_count      <= ESCP_IDLE;
      esc_target     <= 2'd0;
      esc_drcs       <= 1'b0;
      pend_valid     <= 1'b0;
      pend_first     <= 7'd0;
      pend_set       <= SET_DRCS;
    end else if (accept) begin
      if (wr_en) begin
        designation[esc_target] <= wr_set;
      end
      gl_select  <= gl_select_next;
      gr_select  <= gr_select_next;
      ss_valid   <= ss_valid_next;
      ss_select  <= ss_select_next;
      esc_count  <= esc_count_next;
      esc_target <= esc_target_next;
      esc_drcs   <= esc_drcs_next;
      pend_valid <= pend_valid_next;
      pend_first <= pend_first_next;
      pend_set   <= pend_set_next;
    end
  end

endmodule

FILE: rtl/bts_out_reg.sv
module bts_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 res_valid,
  input  bts_pkg::bts_result_t res,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bts_pkg::bts_result_t out_res
);
  import bts_pkg::*;

  // a held result leaves on the same edge that the next byte enters
  assign can_accept = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_res <= res;
    end
  end

endmodule

FILE: rtl/bts_checker.sv
`include "assert_macros.svh"

module bts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import bts_pkg::*;

  logic [SetW-1:0] out_set;
  logic            wide_ok;
  logic            narrow_ok;
  logic [25:0]     out_word;

  assign out_set   = m_tdata[SetW-1:0];
  assign wide_ok   = set_emits(out_set) && set_is_wide(out_set);
  assign narrow_ok = m_tdata[23:11] == 13'd0 && set_emits(out_set) && !set_is_wide(out_set);
  assign out_word  = {m_tuser, m_tdata};

  // a space result carries nothing else
  `ASSERT_IMPL(a_space_clean, clk, rst, m_tvalid && m_tuser[0], m_tdata == 24'd0 && !m_tuser[1])

  // two-byte codes only come from the double-byte sets that emit
  `ASSERT_IMPL(a_wide_set, clk, rst, m_tvalid && m_tuser[1], wide_ok)

  // single-byte results come from a narrow emitting set with a 7-bit code
  `ASSERT_IMPL(a_narrow_set, clk, rst, m_tvalid && !m_tuser[0] && !m_tuser[1], narrow_ok)

  // an empty output register never blocks the input
  `ASSERT_IMPL(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

endmodule

bind broadcast_text_shift_decoder_top bts_checker u_bts_checker (.*);

FILE: tb/tb.sv
module tb;
  import bts_pkg::*;

  typedef enum logic [2:0] {
    ROW_PRED,   // expectation comes from the predictor
    ROW_NONE,   // byte yields no result
    ROW_SPACE,
    ROW_CHAR,
    ROW_WIDE
  } row_kind_t;

  typedef struct packed {
    logic [7:0]       b;
    logic             l;
    row_kind_t        kind;
    logic [SetW-1:0]  cset;
    logic [CodeW-1:0] code;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  broadcast_text_shift_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // shift state mirror
  logic [SetW-1:0] g_set [4];
  logic [1:0]      gl_sel, gr_sel, ss_sel;
  logic            ss_on;
  logic [2:0]      esc_pos;
  logic [1:0]      esc_tgt;
  logic            esc_drcs;
  logic            half_on;
  logic [6:0]      half_hi;
  logic [SetW-1:0] half_set;

  bts_result_t char_q [$];
  int          bad_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  // row attributes of the byte currently offered
  row_kind_t        cur_kind = ROW_PRED;
  logic [SetW-1:0]  cur_set = '0;
  logic [CodeW-1:0] cur_code = '0;

  logic [7:0] text_q [$];

  task automatic restore_defaults();
    g_set[0] = SET_KANJI;
    g_set[1] = SET_ALNUM;
    g_set[2] = SET_HIRA;
    g_set[3] = SET_KATA;
    gl_sel   = 2'd0;
    gr_sel   = 2'd2;
    ss_on    = 1'b0;
    ss_sel   = 2'd0;
    esc_pos  = ESCP_IDLE;
    esc_tgt  = 2'd0;
    esc_drcs = 1'b0;
    half_on  = 1'b0;
    half_hi  = '0;
    half_set = SET_DRCS;
  endtask

  function automatic logic two_byte_set(input logic [SetW-1:0] s);
    return s inside {SET_KANJI, SET_JIS_K1, SET_JIS_K2, SET_ADD_SYM};
  endfunction

  // drcs, mosaic and additional symbols produce no character
  function automatic logic char_set_ok(input logic [SetW-1:0] s);
    return !(s inside {SET_DRCS, SET_MOSAIC_A, SET_MOSAIC_B, SET_MOSAIC_C, SET_MOSAIC_D,
                       SET_ADD_SYM});
  endfunction

  // {hit, set} for a graphic set designation final
  function automatic logic [SetW:0] designated_set(input logic [7:0] b);
    case (b)
      8'h42:   return {1'b1, SET_KANJI};
      8'h4A:   return {1'b1, SET_ALNUM};
      8'h30:   return {1'b1, SET_HIRA};
      8'h31:   return {1'b1, SET_KATA};
      8'h32:   return {1'b1, SET_MOSAIC_A};
      8'h33:   return {1'b1, SET_MOSAIC_B};
      8'h34:   return {1'b1, SET_MOSAIC_C};
      8'h35:   return {1'b1, SET_MOSAIC_D};
      8'h36:   return {1'b1, SET_P_ALNUM};
      8'h37:   return {1'b1, SET_P_HIRA};
      8'h38:   return {1'b1, SET_P_KATA};
      8'h49:   return {1'b1, SET_JIS_KATA};
      8'h39:   return {1'b1, SET_JIS_K1};
      8'h3A:   return {1'b1, SET_JIS_K2};
      8'h3B:   return {1'b1, SET_ADD_SYM};
      default: return {1'b0, SET_DRCS};
    endcase
  endfunction

  function automatic logic drcs_ok(input logic [7:0] b);
    return b inside {[8'h40:8'h4F], ESC_MACRO};
  endfunction

  task automatic escape_step(input logic [7:0] b);
    logic [SetW:0] gf;
    gf = designated_set(b);
    case (esc_pos)
      ESCP_FIRST: begin
        esc_pos = ESCP_SECOND;
        case (b)
          ESC_LS2:  begin gl_sel = 2'd2; esc_pos = ESCP_IDLE; end
          ESC_LS3:  begin gl_sel = 2'd3; esc_pos = ESCP_IDLE; end
          ESC_LS1R: begin gr_sel = 2'd1; esc_pos = ESCP_IDLE; end
          ESC_LS2R: begin gr_sel = 2'd2; esc_pos = ESCP_IDLE; end
          ESC_LS3R: begin gr_sel = 2'd3; esc_pos = ESCP_IDLE; end
          ESC_DBL, ESC_G0: esc_tgt = 2'd0;
          ESC_G1:   esc_tgt = 2'd1;
          ESC_G2:   esc_tgt = 2'd2;
          ESC_G3:   esc_tgt = 2'd3;
          default:  esc_pos = ESCP_IDLE;
        endcase
      end
      ESCP_SECOND: begin
        if (gf[SetW]) begin
          g_set[esc_tgt] = gf[SetW-1:0];
          esc_pos = ESCP_IDLE;
        end else begin
          esc_pos = ESCP_THIRD;
          case (b)
            ESC_DRCS: esc_drcs = 1'b1;
            ESC_G0:   begin esc_drcs = 1'b1; esc_tgt = 2'd0; end
            ESC_G1:   begin esc_drcs = 1'b0; esc_tgt = 2'd1; end
            ESC_G2:   begin esc_drcs = 1'b0; esc_tgt = 2'd2; end
            ESC_G3:   begin esc_drcs = 1'b0; esc_tgt = 2'd3; end
            default:  esc_pos = ESCP_IDLE;
          endcase
        end
      end
      ESCP_THIRD: begin
        esc_pos = ESCP_IDLE;
        if (esc_drcs && drcs_ok(b)) begin
          g_set[esc_tgt] = SET_DRCS;
        end else if (!esc_drcs && gf[SetW]) begin
          g_set[esc_tgt] = gf[SetW-1:0];
        end else if (b == ESC_DRCS) begin
          esc_drcs = 1'b1;
          esc_pos = ESCP_FOURTH;
        end
      end
      ESCP_FOURTH: begin
        if (drcs_ok(b)) g_set[esc_tgt] = SET_DRCS;
        esc_pos = ESCP_IDLE;
      end
      default: esc_pos = ESCP_IDLE;
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic l,
                             output logic got, output bts_result_t res);
    logic [SetW-1:0] s;
    got = 1'b0;
    res = '0;
    if (half_on) begin
      // any byte completes a pending double-byte character
      half_on = 1'b0;
      if (char_set_ok(half_set)) begin
        got = 1'b1;
        res.char_set = half_set;
        res.char_code = {half_hi, 1'b0, b[6:0]};
        res.double_byte = 1'b1;
      end
    end else if (esc_pos != ESCP_IDLE) begin
      escape_step(b);
    end else if (b inside {[GL_LO:GL_HI], [GR_LO:GR_HI]}) begin
      if (b[7]) begin
        s = g_set[gr_sel];
      end else begin
        s = ss_on ? g_set[ss_sel] : g_set[gl_sel];
        ss_on = 1'b0;
      end
      if (two_byte_set(s)) begin
        half_on = 1'b1;
        half_hi = b[6:0];
        half_set = s;
      end else if (char_set_ok(s)) begin
        got = 1'b1;
        res.char_set = s;
        res.char_code = {8'h00, b[6:0]};
      end
    end else begin
      case (b)
        BYTE_LS0: gl_sel = 2'd0;
        BYTE_LS1: gl_sel = 2'd1;
        BYTE_SS2: begin ss_on = 1'b1; ss_sel = 2'd2; end
        BYTE_SS3: begin ss_on = 1'b1; ss_sel = 2'd3; end
        BYTE_ESC: esc_pos = ESCP_FIRST;
        BYTE_SP, BYTE_SP_GR: begin
          got = 1'b1;
          res.is_space = 1'b1;
        end
        default: ;
      endcase
    end
    if (l) restore_defaults();
  endtask

  // scoreboard: results are checked before the new byte's expectation is queued
  always @(posedge clk) begin
    logic        got;
    bts_result_t exp_r;
    bts_result_t act_r;
    if (rst) begin
      restore_defaults();
    end else begin
      if (m_tvalid && m_tready) begin
        act_r = '0;
        act_r.is_space = m_tuser[0];
        act_r.double_byte = m_tuser[1];
        act_r.char_set = m_tdata[3:0];
        act_r.char_code = m_tdata[18:4];
        if (char_q.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected result: sp=%0d set=%0d code=%h dbl=%0d",
                     act_r.is_space, act_r.char_set, act_r.char_code, act_r.double_byte);
          bad_count++;
        end else begin
          exp_r = char_q.pop_front();
          if (act_r.is_space !== exp_r.is_space || act_r.char_set !== exp_r.char_set ||
              act_r.char_code !== exp_r.char_code ||
              act_r.double_byte !== exp_r.double_byte) begin
            // fields shown as space/set/code/double
            if (bad_count < 10)
              $display("mismatch: expected %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                       exp_r.is_space, exp_r.char_set, exp_r.char_code, exp_r.double_byte,
                       act_r.is_space, act_r.char_set, act_r.char_code, act_r.double_byte);
            bad_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast, got, exp_r);
        if (cur_kind != ROW_PRED) begin
          got = cur_kind != ROW_NONE;
          exp_r = '0;
          exp_r.is_space = cur_kind == ROW_SPACE;
          exp_r.char_set = cur_set;
          exp_r.char_code = cur_code;
          exp_r.double_byte = cur_kind == ROW_WIDE;
        end
        if (got) char_q.push_back(exp_r);
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic l, input row_kind_t k,
                           input logic [SetW-1:0] cs, input logic [CodeW-1:0] cc);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    cur_kind <= k;
    cur_set  <= cs;
    cur_code <= cc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  logic [7:0] gfinals [15] = '{8'h42, 8'h4A, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                               8'h36, 8'h37, 8'h38, 8'h49, 8'h39, 8'h3A, 8'h3B};
  logic [7:0] gsel_bytes [4] = '{ESC_G0, ESC_G1, ESC_G2, ESC_G3};
  logic [7:0] lshift_bytes [5] = '{ESC_LS2, ESC_LS3, ESC_LS1R, ESC_LS2R, ESC_LS3R};
  logic [7:0] shift_bytes [4] = '{BYTE_LS0, BYTE_LS1, BYTE_SS2, BYTE_SS3};

  function automatic logic [7:0] drcs_final_byte();
    if ($urandom_range(16) == 16) return ESC_MACRO;
    return {4'h4, 4'($urandom_range(15))};
  endfunction

  task automatic push_escape();
    int n;
    text_q.push_back(BYTE_ESC);
    case ($urandom_range(6))
      0: text_q.push_back(lshift_bytes[$urandom_range(4)]);
      1: begin
        text_q.push_back(gsel_bytes[$urandom_range(3)]);
        text_q.push_back(gfinals[$urandom_range(14)]);
      end
      2: begin
        text_q.push_back(ESC_DBL);
        text_q.push_back(gfinals[$urandom_range(14)]);
      end
      3: begin
        text_q.push_back(ESC_DBL);
        text_q.push_back(gsel_bytes[$urandom_range(3)]);
        text_q.push_back(gfinals[$urandom_range(14)]);
      end
      4: begin
        text_q.push_back(gsel_bytes[$urandom_range(3)]);
        text_q.push_back(ESC_DRCS);
        text_q.push_back(drcs_final_byte());
      end
      5: begin
        text_q.push_back(ESC_DBL);
        text_q.push_back(gsel_bytes[$urandom_range(3)]);
        text_q.push_back(ESC_DRCS);
        text_q.push_back(drcs_final_byte());
      end
      default: begin
        // broken sequence
        n = $urandom_range(1, 3);
        repeat (n) text_q.push_back(8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic build_text();
    int nseg;
    int k;
    text_q.delete();
    nseg = $urandom_range(1, 10);
    repeat (nseg) begin
      k = $urandom_range(99);
      if (k < 28) begin
        text_q.push_back(8'($urandom_range(GL_LO, GL_HI)));
      end else if (k < 48) begin
        text_q.push_back(8'($urandom_range(GR_LO, GR_HI)));
      end else if (k < 55) begin
        text_q.push_back($urandom_range(1) ? BYTE_SP : BYTE_SP_GR);
      end else if (k < 65) begin
        text_q.push_back(shift_bytes[$urandom_range(3)]);
      end else if (k < 80) begin
        push_escape();
      end else if (k < 88) begin
        text_q.push_back(8'($urandom_range(255)));
      end else begin
        // lead byte followed by a second byte of any value
        text_q.push_back(8'($urandom_range(GL_LO, GL_HI)));
        text_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  text_row_t dir_rows [28] = '{
    '{8'h20,    1'b0, ROW_SPACE, SET_DRCS,  15'h0000},
    '{8'hA0,    1'b0, ROW_SPACE, SET_DRCS,  15'h0000},
    '{8'h21,    1'b0, ROW_NONE,  SET_DRCS,  15'h0000},
    '{8'h7E,    1'b0, ROW_WIDE,  SET_KANJI, 15'h217E},
    '{8'h30,    1'b0, ROW_NONE,  SET_DRCS,  15'h0000},
    '{8'hFF,    1'b0, ROW_WIDE,  SET_KANJI, 15'h307F},
    '{8'hA1,    1'b0, ROW_CHAR,  SET_HIRA,  15'h0021},
    '{8'hFE,    1'b0, ROW_CHAR,  SET_HIRA,  15'h007E},
    '{8'h7F,    1'b0, ROW_NONE,  SET_DRCS,  15'h0000},
    '{BYTE_LS1, 1'b0, ROW_NONE,  SET_DRCS,  15'h0000},
    '{8'h41,    1'b0, ROW_CHAR,  SET_ALNUM, 15'h0041},
    '{BYTE_SS3, 1'b0, ROW_NONE,  SET_DRCS,  15'h0000},
    '{8'h21,    1'b0, ROW_CHAR,  SET_KATA,  15'h0021},
    '{8'h42,    1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{BYTE_ESC, 1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{ESC_LS3R, 1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{8'hC0,    1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{BYTE_ESC, 1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{ESC_G1,   1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{ESC_DRCS, 1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{8'h41,    1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{8'h30,    1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{BYTE_ESC, 1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{8'h00,    1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{BYTE_LS0, 1'b0, ROW_PRED,  SET_DRCS,  15'h0000},
    '{8'h50,    1'b1, ROW_PRED,  SET_DRCS,  15'h0000},
    '{8'h21,    1'b0, ROW_NONE,  SET_DRCS,  15'h0000},
    '{8'h22,    1'b0, ROW_WIDE,  SET_KANJI, 15'h2122}
  };

  int phase_idle [8]  = '{0, 78, 0, 31, 0, 78, 0, 31};
  int phase_stall [8] = '{0, 0, 78, 31, 0, 0, 78, 31};

  initial begin
    int sent;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].kind, dir_rows[i].cset,
                dir_rows[i].code);
    for (int p = 0; p < 8; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      sent = 0;
      while (sent < 110) begin
        build_text();
        for (int i = 0; i < text_q.size(); i++)
          send_byte(text_q[i], i == text_q.size() - 1, ROW_PRED, '0, '0);
        sent += text_q.size();
      end
    end
    s_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_count == 0 && char_q.size() == 0) begin
      $display("PASS broadcast_text_shift_decoder_top");
    end else begin
      $display("FAIL broadcast_text_shift_decoder_top");
    end
    $finish;
  end

  initial begin
    #3600000;
    $display("FAIL broadcast_text_shift_decoder_top");
    $finish;
  end

endmodule
